### sv/pmfu_pkg.sv
package pmfu_pkg;

    // Default number of fraction bits of positions and velocities.
    localparam int FRAC_BITS_DEF = 8;

    // Field widths.
    localparam int POS_W    = 21;
    localparam int VEL_W    = 16;
    localparam int BLEND_W  = 6;
    localparam int DELAY_W  = 16;
    localparam int SCROLL_W = 9;
    localparam int GAIN_W   = 18;
    localparam int FADE_W   = 6;
    localparam int VIEW_W   = 12;

    // Signed working width for position sums and bound compares. It covers
    // the widest bound, (4095 + 25) << 8 at the default FRAC_BITS, with room to spare.
    localparam int CALC_W = 28;

    // Stream word widths, padded to whole bytes.
    localparam int S_DATA_W = 112;
    localparam int M_DATA_W = 104;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    localparam logic [CFG_IDX_W-1:0] REG_DAMPING_GAIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_RATE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_HEIGHT  = 3'd3;

    localparam logic [GAIN_W-1:0] DAMPING_GAIN_RST = 18'd65536;
    localparam logic [FADE_W-1:0] FADE_RATE_RST    = 6'd1;
    localparam logic [VIEW_W-1:0] VIEW_WIDTH_RST   = 12'd640;
    localparam logic [VIEW_W-1:0] VIEW_HEIGHT_RST  = 12'd480;

    // Geometry and blend constants, in whole pixels or blend steps.
    localparam int EDGE_MARGIN = 32;
    localparam int FOOTPRINT   = 7;
    localparam logic [BLEND_W:0] BLEND_FULL = 7'd32;

    // Product of a velocity and the damping gain, and its Q2.16 shift.
    localparam int PROD_W     = VEL_W + GAIN_W + 1;
    localparam int GAIN_SHIFT = 16;

    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic signed [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
    localparam logic signed [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};

    typedef struct packed {
        logic [GAIN_W-1:0] damping_gain;
        logic [FADE_W-1:0] fade_rate;
        logic [VIEW_W-1:0] view_width;
        logic [VIEW_W-1:0] view_height;
    } pmfu_cfg_t;

    typedef struct packed {
        logic signed [POS_W-1:0]    pos_x;
        logic signed [POS_W-1:0]    pos_y;
        logic signed [VEL_W-1:0]    vel_x;
        logic signed [VEL_W-1:0]    vel_y;
        logic [BLEND_W-1:0]         blend_level;
        logic                       alive;
        logic                       ground_scroll;
        logic                       reverse_fade;
        logic [DELAY_W-1:0]         delay_count;
        logic signed [SCROLL_W-1:0] scroll_delta;
        logic                       last_of_system;
    } pmfu_in_t;

    typedef struct packed {
        logic signed [POS_W-1:0] new_pos_x;
        logic signed [POS_W-1:0] new_pos_y;
        logic signed [VEL_W-1:0] new_vel_x;
        logic signed [VEL_W-1:0] new_vel_y;
        logic [BLEND_W-1:0]      new_blend_level;
        logic                    still_alive;
        logic                    system_delayed;
        logic [DELAY_W-1:0]      new_delay;
        logic                    end_of_system;
        logic                    remove_system;
    } pmfu_out_t;

    // Clamp a working-width value to the position range.
    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [CALC_W-1:0] v);
        logic signed [POS_W-1:0] r;
        if (v > CALC_W'(POS_MAX))
            r = POS_MAX;
        else if (v < CALC_W'(POS_MIN))
            r = POS_MIN;
        else
            r = v[POS_W-1:0];
        return r;
    endfunction

endpackage

### sv/particle_motion_fade_update.sv
// Particle motion and fade update.
//
// Particle records arrive as words on the s_ stream, one particle per word,
// with tlast marking the final particle of a particle system. Each word is
// captured in an input register, updated by one pass of logic (scroll, two
// damping multiplies, motion, bounds and blend ramp) and stored in a result
// register that drives the m_ stream, where tlast repeats the end marker.
// The block takes one word per cycle while m_tready is high. Each word
// goes from the input register to the result register, which drives m_tdata.
// When the receiver holds m_tready low the result register holds its word,
// the input register still takes one more word, and s_tready then falls
// until the result moves on. No word is dropped or repeated.
// The configuration channel writes damping_gain, fade_rate, view_width and
// view_height by index; it is always ready and should be used while the
// stream is idle. Reset returns the registers to their defaults, empties
// both pipeline registers and clears the per-system "any particle alive"
// flag, which is otherwise cleared after every word that carries tlast.
module particle_motion_fade_update #(
    parameter int FRAC_BITS = pmfu_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // pos_x[20:0], pos_y[41:21], vel_x[57:42], vel_y[73:58], blend_level[79:74],
    // alive[80], ground_scroll[81], reverse_fade[82], delay_count[98:83],
    // scroll_delta[107:99], zero fill above.
    input  logic [pmfu_pkg::S_DATA_W-1:0]     s_tdata,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // new_pos_x[20:0], new_pos_y[41:21], new_vel_x[57:42], new_vel_y[73:58],
    // new_blend_level[79:74], still_alive[80], system_delayed[81],
    // new_delay[97:82], remove_system[98], zero fill above.
    output logic [pmfu_pkg::M_DATA_W-1:0]     m_tdata,
    output logic                              m_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pmfu_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pmfu_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import pmfu_pkg::*;

    pmfu_cfg_t cfg;
    pmfu_in_t  in_word;
    pmfu_in_t  in_item_reg;
    pmfu_out_t out_item_reg;
    pmfu_out_t result;
    logic      in_valid_reg;
    logic      out_valid_reg;
    logic      any_alive_reg;
    logic      any_alive_next;
    logic      set_alive;
    logic      advance;
    logic      s_take;

    pmfu_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Unpack the input word.
    assign in_word.pos_x          = s_tdata[20:0];
    assign in_word.pos_y          = s_tdata[41:21];
    assign in_word.vel_x          = s_tdata[57:42];
    assign in_word.vel_y          = s_tdata[73:58];
    assign in_word.blend_level    = s_tdata[79:74];
    assign in_word.alive          = s_tdata[80];
    assign in_word.ground_scroll  = s_tdata[81];
    assign in_word.reverse_fade   = s_tdata[82];
    assign in_word.delay_count    = s_tdata[98:83];
    assign in_word.scroll_delta   = s_tdata[107:99];
    assign in_word.last_of_system = s_tlast;

    // A word moves from the input register to the result register whenever
    // the result register is empty or being drained this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    pmfu_core #(
        .FRAC_BITS (FRAC_BITS)
    ) u_core (
        .item           (in_item_reg),
        .cfg            (cfg),
        .any_alive_seen (any_alive_reg),
        .result         (result),
        .set_alive      (set_alive)
    );

    // The flag is updated only when a word is actually processed, so
    // stalls never count a particle twice.
    always_comb
    begin
        any_alive_next = any_alive_reg;
        if (advance)
        begin
            if (in_item_reg.last_of_system)
                any_alive_next = 1'b0;
            else if (set_alive)
                any_alive_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            any_alive_reg <= 1'b0;
        end
        else
        begin
            any_alive_reg <= any_alive_next;
            if (s_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_take)
            in_item_reg <= in_word;
        if (advance)
            out_item_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_item_reg.end_of_system;
    assign m_tdata  = {5'd0,
                       out_item_reg.remove_system,
                       out_item_reg.new_delay,
                       out_item_reg.system_delayed,
                       out_item_reg.still_alive,
                       out_item_reg.new_blend_level,
                       out_item_reg.new_vel_y,
                       out_item_reg.new_vel_x,
                       out_item_reg.new_pos_y,
                       out_item_reg.new_pos_x};

endmodule

### sv/pmfu_cfg.sv
module pmfu_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [pmfu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pmfu_pkg::CFG_DATA_W-1:0] cfg_data,
    output pmfu_pkg::pmfu_cfg_t        cfg
);
    import pmfu_pkg::*;

    pmfu_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Writes to indexes beyond the register list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.damping_gain <= DAMPING_GAIN_RST;
            cfg_reg.fade_rate    <= FADE_RATE_RST;
            cfg_reg.view_width   <= VIEW_WIDTH_RST;
            cfg_reg.view_height  <= VIEW_HEIGHT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_DAMPING_GAIN: cfg_reg.damping_gain <= cfg_data[GAIN_W-1:0];
                REG_FADE_RATE:    cfg_reg.fade_rate    <= cfg_data[FADE_W-1:0];
                REG_VIEW_WIDTH:   cfg_reg.view_width   <= cfg_data[VIEW_W-1:0];
                REG_VIEW_HEIGHT:  cfg_reg.view_height  <= cfg_data[VIEW_W-1:0];
                default:          ;
            endcase
        end
    end

endmodule

### sv/pmfu_core.sv
module pmfu_core #(
    parameter int FRAC_BITS = pmfu_pkg::FRAC_BITS_DEF
) (
    input  pmfu_pkg::pmfu_in_t  item,
    input  pmfu_pkg::pmfu_cfg_t cfg,
    input  logic                any_alive_seen,
    output pmfu_pkg::pmfu_out_t result,
    output logic                set_alive
);
    import pmfu_pkg::*;

    localparam logic signed [CALC_W-1:0] X_LO = CALC_W'(-EDGE_MARGIN) <<< FRAC_BITS;

    logic                       delayed;
    logic [DELAY_W-1:0]         nd;
    logic signed [CALC_W-1:0]   scroll_s;
    logic signed [POS_W-1:0]    y_scr;
    logic signed [PROD_W-1:0]   prod_x;
    logic signed [PROD_W-1:0]   prod_y;
    logic signed [PROD_W-GAIN_SHIFT-1:0] q_x;
    logic signed [PROD_W-GAIN_SHIFT-1:0] q_y;
    logic signed [VEL_W-1:0]    vx_d;
    logic signed [VEL_W-1:0]    vy_d;
    logic signed [POS_W-1:0]    x_mv;
    logic signed [POS_W-1:0]    y_mv;
    logic signed [CALC_W-1:0]   x_hi;
    logic signed [CALC_W-1:0]   y_hi;
    logic                       view_hit;
    logic [BLEND_W:0]           blend_up;
    logic [BLEND_W:0]           blend_dn;
    logic [BLEND_W-1:0]         blend_new;
    logic                       stays;

    assign nd      = (item.delay_count == '0) ? '0 : item.delay_count - 1'b1;
    assign delayed = (nd != '0);

    // Ground-space systems pick up the scroll in whole pixels first.
    assign scroll_s = CALC_W'(item.scroll_delta) <<< FRAC_BITS;
    assign y_scr    = item.ground_scroll ? sat_pos(CALC_W'(item.pos_y) + scroll_s) : item.pos_y;

    // Damping: signed velocity times unsigned Q2.16 gain, floored.
    assign prod_x = item.vel_x * signed'({1'b0, cfg.damping_gain});
    assign prod_y = item.vel_y * signed'({1'b0, cfg.damping_gain});
    assign q_x    = prod_x[PROD_W-1:GAIN_SHIFT];
    assign q_y    = prod_y[PROD_W-1:GAIN_SHIFT];

    always_comb
    begin
        if (q_x > (PROD_W-GAIN_SHIFT)'(VEL_MAX))
            vx_d = VEL_MAX;
        else if (q_x < (PROD_W-GAIN_SHIFT)'(VEL_MIN))
            vx_d = VEL_MIN;
        else
            vx_d = q_x[VEL_W-1:0];
        if (q_y > (PROD_W-GAIN_SHIFT)'(VEL_MAX))
            vy_d = VEL_MAX;
        else if (q_y < (PROD_W-GAIN_SHIFT)'(VEL_MIN))
            vy_d = VEL_MIN;
        else
            vy_d = q_y[VEL_W-1:0];
    end

    assign x_mv = sat_pos(CALC_W'(item.pos_x) + CALC_W'(vx_d));
    assign y_mv = sat_pos(CALC_W'(y_scr) + CALC_W'(vy_d));

    // The footprint is folded into the upper bounds.
    assign x_hi = (signed'(CALC_W'(cfg.view_width)) + CALC_W'(EDGE_MARGIN - FOOTPRINT))
                  <<< FRAC_BITS;
    assign y_hi = (signed'(CALC_W'(cfg.view_height)) - CALC_W'(FOOTPRINT)) <<< FRAC_BITS;

    assign view_hit = (CALC_W'(x_mv) >= X_LO) && (CALC_W'(x_mv) <= x_hi) &&
                      !y_mv[POS_W-1] && (CALC_W'(y_mv) <= y_hi);

    assign blend_up = {1'b0, item.blend_level} + {1'b0, cfg.fade_rate};
    assign blend_dn = {1'b0, item.blend_level} - {1'b0, cfg.fade_rate};

    always_comb
    begin
        stays     = 1'b0;
        blend_new = item.blend_level;
        if (item.reverse_fade)
        begin
            if (item.blend_level != '0)
            begin
                stays     = 1'b1;
                blend_new = (item.blend_level <= cfg.fade_rate) ? '0 : blend_dn[BLEND_W-1:0];
            end
        end
        else if (view_hit && ({1'b0, item.blend_level} < BLEND_FULL))
        begin
            stays     = 1'b1;
            blend_new = (blend_up > BLEND_FULL) ? BLEND_FULL[BLEND_W-1:0]
                                                : blend_up[BLEND_W-1:0];
        end
    end

    assign set_alive = !delayed && item.alive && stays;

    always_comb
    begin
        result.new_delay      = nd;
        result.system_delayed = delayed;
        result.end_of_system  = item.last_of_system;
        result.remove_system  = item.last_of_system && !delayed &&
                                !(any_alive_seen || set_alive);
        if (!delayed && item.alive)
        begin
            result.new_pos_x       = x_mv;
            result.new_pos_y       = y_mv;
            result.new_vel_x       = vx_d;
            result.new_vel_y       = vy_d;
            result.new_blend_level = blend_new;
            result.still_alive     = stays;
        end
        else
        begin
            result.new_pos_x       = item.pos_x;
            result.new_pos_y       = item.pos_y;
            result.new_vel_x       = item.vel_x;
            result.new_vel_y       = item.vel_y;
            result.new_blend_level = item.blend_level;
            result.still_alive     = delayed && item.alive;
        end
    end

endmodule
